// File: hdl/ntt_pkg.sv
`timescale 1ns / 1ps
package ntt_pkg;
	localparam int PolyLen = 256;
	localparam int IdxW = 8;
	localparam logic signed [31:0] ModQ = 32'sd8380417;
	localparam logic [31:0] MontQinv = 32'd58728449;
	localparam logic signed [31:0] InvScale = 32'sd41978;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_FORWARD = 2'd1,
		OP_INVERSE = 2'd2,
		OP_READ    = 2'd3
	} op_t;

	function automatic logic signed [31:0] twiddle(input logic [7:0] k);
		logic signed [31:0] r;
		case (k)
			8'd0: r = 32'sd0; 8'd1: r = 32'sd25847; 8'd2: r = -32'sd2608894;
			8'd3: r = -32'sd518909; 8'd4: r = 32'sd237124; 8'd5: r = -32'sd777960;
			8'd6: r = -32'sd876248; 8'd7: r = 32'sd466468; 8'd8: r = 32'sd1826347;
			8'd9: r = 32'sd2353451; 8'd10: r = -32'sd359251; 8'd11: r = -32'sd2091905;
			8'd12: r = 32'sd3119733; 8'd13: r = -32'sd2884855; 8'd14: r = 32'sd3111497;
			8'd15: r = 32'sd2680103; 8'd16: r = 32'sd2725464; 8'd17: r = 32'sd1024112;
			8'd18: r = -32'sd1079900; 8'd19: r = 32'sd3585928; 8'd20: r = -32'sd549488;
			8'd21: r = -32'sd1119584; 8'd22: r = 32'sd2619752; 8'd23: r = -32'sd2108549;
			8'd24: r = -32'sd2118186; 8'd25: r = -32'sd3859737; 8'd26: r = -32'sd1399561;
			8'd27: r = -32'sd3277672; 8'd28: r = 32'sd1757237; 8'd29: r = -32'sd19422;
			8'd30: r = 32'sd4010497; 8'd31: r = 32'sd280005; 8'd32: r = 32'sd2706023;
			8'd33: r = 32'sd95776; 8'd34: r = 32'sd3077325; 8'd35: r = 32'sd3530437;
			8'd36: r = -32'sd1661693; 8'd37: r = -32'sd3592148; 8'd38: r = -32'sd2537516;
			8'd39: r = 32'sd3915439; 8'd40: r = -32'sd3861115; 8'd41: r = -32'sd3043716;
			8'd42: r = 32'sd3574422; 8'd43: r = -32'sd2867647; 8'd44: r = 32'sd3539968;
			8'd45: r = -32'sd300467; 8'd46: r = 32'sd2348700; 8'd47: r = -32'sd539299;
			8'd48: r = -32'sd1699267; 8'd49: r = -32'sd1643818; 8'd50: r = 32'sd3505694;
			8'd51: r = -32'sd3821735; 8'd52: r = 32'sd3507263; 8'd53: r = -32'sd2140649;
			8'd54: r = -32'sd1600420; 8'd55: r = 32'sd3699596; 8'd56: r = 32'sd811944;
			8'd57: r = 32'sd531354; 8'd58: r = 32'sd954230; 8'd59: r = 32'sd3881043;
			8'd60: r = 32'sd3900724; 8'd61: r = -32'sd2556880; 8'd62: r = 32'sd2071892;
			8'd63: r = -32'sd2797779; 8'd64: r = -32'sd3930395; 8'd65: r = -32'sd1528703;
			8'd66: r = -32'sd3677745; 8'd67: r = -32'sd3041255; 8'd68: r = -32'sd1452451;
			8'd69: r = 32'sd3475950; 8'd70: r = 32'sd2176455; 8'd71: r = -32'sd1585221;
			8'd72: r = -32'sd1257611; 8'd73: r = 32'sd1939314; 8'd74: r = -32'sd4083598;
			8'd75: r = -32'sd1000202; 8'd76: r = -32'sd3190144; 8'd77: r = -32'sd3157330;
			8'd78: r = -32'sd3632928; 8'd79: r = 32'sd126922; 8'd80: r = 32'sd3412210;
			8'd81: r = -32'sd983419; 8'd82: r = 32'sd2147896; 8'd83: r = 32'sd2715295;
			8'd84: r = -32'sd2967645; 8'd85: r = -32'sd3693493; 8'd86: r = -32'sd411027;
			8'd87: r = -32'sd2477047; 8'd88: r = -32'sd671102; 8'd89: r = -32'sd1228525;
			8'd90: r = -32'sd22981; 8'd91: r = -32'sd1308169; 8'd92: r = -32'sd381987;
			8'd93: r = 32'sd1349076; 8'd94: r = 32'sd1852771; 8'd95: r = -32'sd1430430;
			8'd96: r = -32'sd3343383; 8'd97: r = 32'sd264944; 8'd98: r = 32'sd508951;
			8'd99: r = 32'sd3097992; 8'd100: r = 32'sd44288; 8'd101: r = -32'sd1100098;
			8'd102: r = 32'sd904516; 8'd103: r = 32'sd3958618; 8'd104: r = -32'sd3724342;
			8'd105: r = -32'sd8578; 8'd106: r = 32'sd1653064; 8'd107: r = -32'sd3249728;
			8'd108: r = 32'sd2389356; 8'd109: r = -32'sd210977; 8'd110: r = 32'sd759969;
			8'd111: r = -32'sd1316856; 8'd112: r = 32'sd189548; 8'd113: r = -32'sd3553272;
			8'd114: r = 32'sd3159746; 8'd115: r = -32'sd1851402; 8'd116: r = -32'sd2409325;
			8'd117: r = -32'sd177440; 8'd118: r = 32'sd1315589; 8'd119: r = 32'sd1341330;
			8'd120: r = 32'sd1285669; 8'd121: r = -32'sd1584928; 8'd122: r = -32'sd812732;
			8'd123: r = -32'sd1439742; 8'd124: r = -32'sd3019102; 8'd125: r = -32'sd3881060;
			8'd126: r = -32'sd3628969; 8'd127: r = 32'sd3839961; 8'd128: r = 32'sd2091667;
			8'd129: r = 32'sd3407706; 8'd130: r = 32'sd2316500; 8'd131: r = 32'sd3817976;
			8'd132: r = -32'sd3342478; 8'd133: r = 32'sd2244091; 8'd134: r = -32'sd2446433;
			8'd135: r = -32'sd3562462; 8'd136: r = 32'sd266997; 8'd137: r = 32'sd2434439;
			8'd138: r = -32'sd1235728; 8'd139: r = 32'sd3513181; 8'd140: r = -32'sd3520352;
			8'd141: r = -32'sd3759364; 8'd142: r = -32'sd1197226; 8'd143: r = -32'sd3193378;
			8'd144: r = 32'sd900702; 8'd145: r = 32'sd1859098; 8'd146: r = 32'sd909542;
			8'd147: r = 32'sd819034; 8'd148: r = 32'sd495491; 8'd149: r = -32'sd1613174;
			8'd150: r = -32'sd43260; 8'd151: r = -32'sd522500; 8'd152: r = -32'sd655327;
			8'd153: r = -32'sd3122442; 8'd154: r = 32'sd2031748; 8'd155: r = 32'sd3207046;
			8'd156: r = -32'sd3556995; 8'd157: r = -32'sd525098; 8'd158: r = -32'sd768622;
			8'd159: r = -32'sd3595838; 8'd160: r = 32'sd342297; 8'd161: r = 32'sd286988;
			8'd162: r = -32'sd2437823; 8'd163: r = 32'sd4108315; 8'd164: r = 32'sd3437287;
			8'd165: r = -32'sd3342277; 8'd166: r = 32'sd1735879; 8'd167: r = 32'sd203044;
			8'd168: r = 32'sd2842341; 8'd169: r = 32'sd2691481; 8'd170: r = -32'sd2590150;
			8'd171: r = 32'sd1265009; 8'd172: r = 32'sd4055324; 8'd173: r = 32'sd1247620;
			8'd174: r = 32'sd2486353; 8'd175: r = 32'sd1595974; 8'd176: r = -32'sd3767016;
			8'd177: r = 32'sd1250494; 8'd178: r = 32'sd2635921; 8'd179: r = -32'sd3548272;
			8'd180: r = -32'sd2994039; 8'd181: r = 32'sd1869119; 8'd182: r = 32'sd1903435;
			8'd183: r = -32'sd1050970; 8'd184: r = -32'sd1333058; 8'd185: r = 32'sd1237275;
			8'd186: r = -32'sd3318210; 8'd187: r = -32'sd1430225; 8'd188: r = -32'sd451100;
			8'd189: r = 32'sd1312455; 8'd190: r = 32'sd3306115; 8'd191: r = -32'sd1962642;
			8'd192: r = -32'sd1279661; 8'd193: r = 32'sd1917081; 8'd194: r = -32'sd2546312;
			8'd195: r = -32'sd1374803; 8'd196: r = 32'sd1500165; 8'd197: r = 32'sd777191;
			8'd198: r = 32'sd2235880; 8'd199: r = 32'sd3406031; 8'd200: r = -32'sd542412;
			8'd201: r = -32'sd2831860; 8'd202: r = -32'sd1671176; 8'd203: r = -32'sd1846953;
			8'd204: r = -32'sd2584293; 8'd205: r = -32'sd3724270; 8'd206: r = 32'sd594136;
			8'd207: r = -32'sd3776993; 8'd208: r = -32'sd2013608; 8'd209: r = 32'sd2432395;
			8'd210: r = 32'sd2454455; 8'd211: r = -32'sd164721; 8'd212: r = 32'sd1957272;
			8'd213: r = 32'sd3369112; 8'd214: r = 32'sd185531; 8'd215: r = -32'sd1207385;
			8'd216: r = -32'sd3183426; 8'd217: r = 32'sd162844; 8'd218: r = 32'sd1616392;
			8'd219: r = 32'sd3014001; 8'd220: r = 32'sd810149; 8'd221: r = 32'sd1652634;
			8'd222: r = -32'sd3694233; 8'd223: r = -32'sd1799107; 8'd224: r = -32'sd3038916;
			8'd225: r = 32'sd3523897; 8'd226: r = 32'sd3866901; 8'd227: r = 32'sd269760;
			8'd228: r = 32'sd2213111; 8'd229: r = -32'sd975884; 8'd230: r = 32'sd1717735;
			8'd231: r = 32'sd472078; 8'd232: r = -32'sd426683; 8'd233: r = 32'sd1723600;
			8'd234: r = -32'sd1803090; 8'd235: r = 32'sd1910376; 8'd236: r = -32'sd1667432;
			8'd237: r = -32'sd1104333; 8'd238: r = -32'sd260646; 8'd239: r = -32'sd3833893;
			8'd240: r = -32'sd2939036; 8'd241: r = -32'sd2235985; 8'd242: r = -32'sd420899;
			8'd243: r = -32'sd2286327; 8'd244: r = 32'sd183443; 8'd245: r = -32'sd976891;
			8'd246: r = 32'sd1612842; 8'd247: r = -32'sd3545687; 8'd248: r = -32'sd554416;
			8'd249: r = 32'sd3919660; 8'd250: r = -32'sd48306; 8'd251: r = -32'sd1362209;
			8'd252: r = 32'sd3937738; 8'd253: r = 32'sd1400424; 8'd254: r = -32'sd846154;
			default: r = 32'sd1976782;
		endcase
		return r;
	endfunction
endpackage

// File: hdl/ntt_montmul.sv
`timescale 1ns / 1ps
// Montgomery multiply, result in [0,Q).
module ntt_montmul import ntt_pkg::*; (
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic        [31:0] r
);
	logic signed [63:0] p_s1, p_s2;
	logic        [31:0] lo_s2;
	logic signed [31:0] m_s3;
	logic signed [63:0] p_s3;
	logic signed [63:0] mq_s4, p_s4;
	logic signed [31:0] q_s5;
	logic signed [31:0] qv;
	logic signed [63:0] d;

	assign d = p_s4 - mq_s4;

	always_ff @(posedge clk) begin
		p_s1  <= a * b;
		p_s2  <= p_s1;
		lo_s2 <= p_s1[31:0] * MontQinv;
		m_s3  <= lo_s2;
		p_s3  <= p_s2;
		mq_s4 <= m_s3 * ModQ;
		p_s4  <= p_s3;
		q_s5  <= d[63:32];
	end

	// q lies in (-Q, Q) since |p| < 2^31*Q; one conditional add folds it.
	assign qv = q_s5[31] ? q_s5 + ModQ : q_s5;
	assign r  = qv;
endmodule

// File: hdl/ntt_forward_inverse_q8380417.sv
`timescale 1ns / 1ps
// Coefficient store and NTT engine for polynomials modulo 8380417, 256 entries.
// Command channel: a transaction is taken when start is high and busy is low.
//   opcode write stores coef_value at coef_index.
//   opcode read returns the entry at coef_index on read_value, flagged by
//   read_valid for one cycle, after the ST_READ state has registered the entry.
//   opcode forward runs an in-place Cooley-Tukey NTT (bit-reversed output);
//   opcode inverse runs Gentleman-Sande butterflies then scales by 41978.
// Transforms use one shared Montgomery multiplier and a
// single-port coefficient array; every butterfly is sequenced one at a time:
// read u, read v, multiply (waiting out the multiplier), write two results.
// A transform runs eight layers of 128 butterflies; the inverse then adds a
// scaling pass that reads, multiplies and writes back each of the 256 entries.
// busy stays high for the whole transform; nothing is accepted meanwhile.
// There is no backpressure: read_valid fires once and is not held.
// Reset clears the sequencer and strobe; the store is undefined until written.
module ntt_forward_inverse_q8380417 import ntt_pkg::*; #(
	parameter int POLY_LEN = PolyLen
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [7:0]         coef_index,
	input  logic signed [31:0] coef_value,
	output logic               read_valid,
	output logic signed [31:0] read_value
);
	localparam int AW = $clog2(POLY_LEN);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_RDU  = 8'b0000_0010,
		ST_RDV  = 8'b0000_0100,
		ST_MUL  = 8'b0000_1000,
		ST_WRA  = 8'b0001_0000,
		ST_WRB  = 8'b0010_0000,
		ST_READ = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [31:0] mem [POLY_LEN];
	logic [31:0] rd_q, u_q, v_q;
	logic        inv_q, scale_q;
	logic [3:0]  layer_q;     // log2 of len
	logic [AW-1:0] blk_q, j_q; // butterfly counter: group and offset
	logic [AW-1:0] bfly_q;
	logic [2:0]  wait_q;
	logic [AW-1:0] ia, ib, ridx_q;
	logic [AW:0]   len;
	logic [7:0]  k;
	logic signed [31:0] tw, ma, mb;
	logic [31:0] mr;

	ntt_montmul u_mul (.clk(clk), .a(ma), .b(mb), .r(mr));

	// bfly_q enumerates butterflies 0..127 in the layer; len = 2^layer.
	assign len = (AW+1)'(1) << layer_q;
	always_comb begin
		j_q  = bfly_q & AW'(len - 1);
		blk_q = (bfly_q >> layer_q);
		ia   = scale_q ? bfly_q : AW'((blk_q << (layer_q + 1)) + j_q);
		ib   = AW'(ia + len[AW-1:0]);
	end
	// twiddle index: forward k = POLY_LEN/2/len + blk, inverse POLY_LEN/len - 1 - blk
	always_comb begin
		if (inv_q) k = 8'((POLY_LEN >> layer_q) - 1) - 8'(blk_q);
		else k = 8'((POLY_LEN / 2) >> layer_q) + 8'(blk_q);
	end
	always_comb begin
		tw = twiddle(k);
		if (inv_q) tw = -tw;
		if (scale_q) begin
			ma = InvScale;
			mb = u_q;
		end else if (inv_q) begin
			ma = tw;
			mb = u_q - v_q;
		end else begin
			ma = tw;
			mb = v_q;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start && op_t'(opcode) == OP_WRITE) mem[coef_index[AW-1:0]] <= coef_value;
			end
			ST_RDU:  u_q <= mem[ia];
			ST_RDV:  v_q <= mem[ib];
			ST_WRA: begin
				if (scale_q) mem[ia] <= mr;
				else if (inv_q) mem[ia] <= u_q + v_q;
				else mem[ia] <= u_q + mr;
			end
			ST_WRB: begin
				if (inv_q) mem[ib] <= mr;
				else mem[ib] <= u_q - mr;
			end
			ST_READ: rd_q <= mem[ridx_q];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			inv_q   <= 1'b0;
			scale_q <= 1'b0;
			layer_q <= '0;
			bfly_q  <= '0;
			wait_q  <= '0;
			ridx_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						case (op_t'(opcode))
							OP_FORWARD: begin
								state_q <= ST_RDU; inv_q <= 1'b0; scale_q <= 1'b0;
								layer_q <= 4'(AW - 1); bfly_q <= '0;
							end
							OP_INVERSE: begin
								state_q <= ST_RDU; inv_q <= 1'b1; scale_q <= 1'b0;
								layer_q <= '0; bfly_q <= '0;
							end
							OP_READ: begin
								state_q <= ST_READ; ridx_q <= coef_index[AW-1:0];
							end
							default: ;
						endcase
					end
				end
				ST_RDU: state_q <= scale_q ? ST_MUL : ST_RDV;
				ST_RDV: state_q <= ST_MUL;
				ST_MUL: begin
					wait_q <= wait_q + 3'd1;
					if (wait_q == 3'd5) begin
						wait_q <= '0;
						state_q <= ST_WRA;
					end
				end
				ST_WRA: begin
					if (scale_q) begin
						bfly_q <= bfly_q + 1'b1;
						state_q <= (bfly_q == AW'(POLY_LEN - 1)) ? ST_IDLE : ST_RDU;
						if (bfly_q == AW'(POLY_LEN - 1)) scale_q <= 1'b0;
					end else
						state_q <= ST_WRB;
				end
				ST_WRB: begin
					state_q <= ST_RDU;
					if (bfly_q == AW'(POLY_LEN / 2 - 1)) begin
						bfly_q <= '0;
						if (!inv_q) begin
							if (layer_q == '0) state_q <= ST_IDLE;
							else layer_q <= layer_q - 4'd1;
						end else begin
							if (layer_q == 4'(AW - 1)) scale_q <= 1'b1;
							else layer_q <= layer_q + 4'd1;
						end
					end else
						bfly_q <= bfly_q + 1'b1;
				end
				ST_READ: state_q <= ST_OUT;
				ST_OUT:  state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign read_valid = (state_q == ST_OUT);
	assign read_value = rd_q;
endmodule
